/* rtl/assert_macros.svh */
// Assertion helpers used by the divider property checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define DIV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("divider check failed");

// Check that a condition never holds at a rising clock edge outside reset.
`define DIV_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("divider forbidden condition seen");

`endif

/* rtl/div64_pkg.sv */
package div64_pkg;

    localparam int DATA_W = 64;
    localparam int CNT_W  = $clog2(DATA_W);
    localparam int OP_W   = 2;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [OP_W-1:0]   op_t;

    // Op codes: bit 1 selects signed, bit 0 selects remainder.
    localparam op_t OP_UQUO = 2'd0;
    localparam op_t OP_UREM = 2'd1;
    localparam op_t OP_SQUO = 2'd2;
    localparam op_t OP_SREM = 2'd3;

    localparam int OP_SIGNED_BIT = 1;
    localparam int OP_REM_BIT    = 0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FIX
    } state_t;

endpackage

/* rtl/divider_64bit_signed_unsigned.sv */
// From the start beat to the done strobe: 1 load, 64 restoring steps, 1 sign fix and
// the done register; one quotient bit per cycle through a single 65-bit subtractor.
// One item at a time: busy is high while an item is in progress, and a new start is
// taken in the same cycle as the done strobe. The receiver cannot stall the result.
// Reset (rst_n low, asynchronous): sequencer returns to idle, busy and done clear.
module divider_64bit_signed_unsigned
    import div64_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   op,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] answer,
    output logic              divide_by_zero
);

    state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic       done_reg, done_next;

    word_t      rem_reg, rem_next;
    word_t      work_reg, work_next;     // dividend bits shift out, quotient bits shift in
    word_t      dsr_reg, dsr_next;
    logic       neg_q_reg, neg_q_next;
    logic       neg_r_reg, neg_r_next;
    logic       sel_rem_reg, sel_rem_next;
    logic       dz_reg, dz_next;
    word_t      answer_reg, answer_next;
    logic       dz_out_reg, dz_out_next;

    logic       accept;
    logic       do_load;
    logic       do_step;
    logic       do_fix;

    logic       is_signed;
    logic       a_neg;
    logic       b_neg;
    word_t      mag_a;
    word_t      mag_b;

    logic [DATA_W:0] rem_ext;
    logic [DATA_W:0] diff;
    logic            take;
    word_t           fix_val;

    assign accept = start && (state_reg == ST_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        busy    = 1'b1;
        do_load = 1'b0;
        do_step = 1'b0;
        do_fix  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy    = 1'b0;
                do_load = start;
            end
            ST_DIVIDE:
            begin
                do_step = 1'b1;
            end
            ST_FIX:
            begin
                do_fix = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // Operand magnitudes at load.
    always_comb
    begin
        is_signed = op[OP_SIGNED_BIT];
        a_neg     = is_signed && dividend[DATA_W-1];
        b_neg     = is_signed && divisor[DATA_W-1];
        mag_a     = a_neg ? (word_t'(0) - dividend) : dividend;
        mag_b     = b_neg ? (word_t'(0) - divisor) : divisor;
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        rem_ext = {rem_reg, work_reg[DATA_W-1]};
        diff    = rem_ext - {1'b0, dsr_reg};
        take    = !diff[DATA_W];
    end

    always_comb
    begin
        if (sel_rem_reg)
        begin
            fix_val = neg_r_reg ? (word_t'(0) - rem_reg) : rem_reg;
        end
        else
        begin
            fix_val = neg_q_reg ? (word_t'(0) - work_reg) : work_reg;
        end
    end

    always_comb
    begin
        rem_next     = rem_reg;
        work_next    = work_reg;
        dsr_next     = dsr_reg;
        neg_q_next   = neg_q_reg;
        neg_r_next   = neg_r_reg;
        sel_rem_next = sel_rem_reg;
        dz_next      = dz_reg;
        cnt_next     = cnt_reg;
        answer_next  = answer_reg;
        dz_out_next  = dz_out_reg;
        done_next    = 1'b0;

        if (do_load)
        begin
            rem_next     = '0;
            work_next    = mag_a;
            dsr_next     = mag_b;
            neg_q_next   = a_neg ^ b_neg;
            neg_r_next   = a_neg;
            sel_rem_next = op[OP_REM_BIT];
            dz_next      = (divisor == '0);
            cnt_next     = '0;
        end

        if (do_step)
        begin
            rem_next  = take ? diff[DATA_W-1:0] : rem_ext[DATA_W-1:0];
            work_next = {work_reg[DATA_W-2:0], take};
            cnt_next  = cnt_reg + CNT_W'(1);
        end

        if (do_fix)
        begin
            answer_next = dz_reg ? '0 : fix_val;
            dz_out_next = dz_reg;
            done_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= accept ? ST_DIVIDE : state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        work_reg    <= work_next;
        dsr_reg     <= dsr_next;
        neg_q_reg   <= neg_q_next;
        neg_r_reg   <= neg_r_next;
        sel_rem_reg <= sel_rem_next;
        dz_reg      <= dz_next;
        answer_reg  <= answer_next;
        dz_out_reg  <= dz_out_next;
    end

    assign done           = done_reg;
    assign answer         = answer_reg;
    assign divide_by_zero = dz_out_reg;

endmodule

/* rtl/div64_checker.sv */
`include "assert_macros.svh"

module div64_props
    import div64_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [OP_W-1:0]   op,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    input  logic              done,
    input  logic [DATA_W-1:0] answer,
    input  logic              divide_by_zero
);

    // An accepted beat keeps the divider busy.
    `DIV_ASSERT(a_start_busy, clk, rst_n, (start && !busy) |=> busy)
    // The strobe comes at the end of a busy stretch, with busy already dropped.
    `DIV_ASSERT(a_done_after_busy, clk, rst_n, done |-> (!busy && $past(busy)))
    // One strobe per item.
    `DIV_ASSERT(a_done_pulse, clk, rst_n, done |=> !done)
    // Divide by zero answers zero.
    `DIV_NEVER(a_dz_zero, clk, rst_n, done && divide_by_zero && (answer != '0))

endmodule

bind divider_64bit_signed_unsigned div64_props u_div64_props (.*);

/* test/div64_checker.sv */
module div64_checker
    import div64_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  busy,
    input  op_t   op,
    input  word_t dividend,
    input  word_t divisor,
    input  logic  done,
    input  word_t answer,
    input  logic  divide_by_zero,
    output int    owed,
    output int    mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        word_t answer;
        logic  dbz;
    } div_result_t;

    div_result_t answers_owed[$];
    int          taken_cnt = 0;
    int          given_cnt = 0;
    int          err_cnt   = 0;

    assign owed       = taken_cnt - given_cnt;
    assign mismatches = err_cnt;

    // Truncating division on magnitudes, then sign fix-up.
    function automatic div_result_t truncated_divide(op_t code, word_t num, word_t den);
        div_result_t res;
        word_t       mag_n;
        word_t       mag_d;
        word_t       quo;
        word_t       rem;
        logic        neg_n;
        logic        neg_d;
        neg_n = code[OP_SIGNED_BIT] & num[DATA_W-1];
        neg_d = code[OP_SIGNED_BIT] & den[DATA_W-1];
        res.dbz = (den == '0);
        res.answer = '0;
        if (!res.dbz)
        begin
            // the most negative value negates to itself, read as unsigned 2^63
            mag_n = neg_n ? -num : num;
            mag_d = neg_d ? -den : den;
            quo = mag_n / mag_d;
            rem = mag_n % mag_d;
            if (code[OP_REM_BIT])
                res.answer = neg_n ? -rem : rem;
            else
                res.answer = (neg_n ^ neg_d) ? -quo : quo;
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        div_result_t want;
        if (rst_n)
        begin
            // compare first: a new beat may be taken on the done cycle
            if (done)
            begin
                if (answers_owed.size() == 0)
                begin
                    $display("%0t: result with nothing expected: answer %h dbz %b",
                             $time, answer, divide_by_zero);
                    err_cnt++;
                end
                else
                begin
                    want = answers_owed.pop_front();
                    if (answer !== want.answer)
                    begin
                        $display("%0t: answer mismatch: expected %h actual %h",
                                 $time, want.answer, answer);
                        err_cnt++;
                    end
                    if (divide_by_zero !== want.dbz)
                    begin
                        $display("%0t: divide_by_zero mismatch: expected %b actual %b",
                                 $time, want.dbz, divide_by_zero);
                        err_cnt++;
                    end
                    given_cnt <= given_cnt + 1;
                end
            end
            if (start && !busy)
            begin
                answers_owed.push_back(truncated_divide(op, dividend, divisor));
                taken_cnt <= taken_cnt + 1;
            end
        end
    end

endmodule

/* test/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import div64_pkg::*;

    localparam int    LIMIT_CYCLES    = 1_000_000;
    localparam int    ITEMS_PER_PHASE = 460;
    localparam int    SETTLE_CYCLES   = 70;
    localparam word_t MOST_NEG        = {1'b1, {(DATA_W-1){1'b0}}};
    localparam word_t MOST_POS        = {1'b0, {(DATA_W-1){1'b1}}};
    localparam word_t ALL_ONES        = '1;

    logic  clk            = 1'b0;
    logic  rst_n          = 1'b0;
    logic  start          = 1'b0;
    op_t   op             = OP_UQUO;
    word_t dividend       = '0;
    word_t divisor        = '0;
    logic  busy;
    logic  done;
    word_t answer;
    logic  divide_by_zero;
    int    owed;
    int    mismatches;
    int    cycles         = 0;
    int    idle_pct[3]    = '{11, 53, 0};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    divider_64bit_signed_unsigned dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .dividend       (dividend),
        .divisor        (divisor),
        .done           (done),
        .answer         (answer),
        .divide_by_zero (divide_by_zero)
    );

    div64_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .dividend       (dividend),
        .divisor        (divisor),
        .done           (done),
        .answer         (answer),
        .divide_by_zero (divide_by_zero),
        .owed           (owed),
        .mismatches     (mismatches)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("divider_64bit_signed_unsigned verification failed");
            $finish;
        end
    end

    // Mix of full-width, narrow, tiny and boundary values of either sign.
    function automatic word_t pick_operand();
        word_t w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: w = w >> $urandom_range(1, DATA_W-1);
            1: w = word_t'($urandom_range(0, 20));
            2: w = -word_t'($urandom_range(1, 20));
            3:
            begin
                case ($urandom_range(0, 4))
                    0: w = '0;
                    1: w = word_t'(1);
                    2: w = ALL_ONES;
                    3: w = MOST_NEG;
                    default: w = MOST_POS;
                endcase
            end
            4: w = ~(w >> $urandom_range(1, DATA_W-1));
            default: ;
        endcase
        return w;
    endfunction

    function automatic word_t pick_divisor();
        if ($urandom_range(0, 29) == 0)
            return '0;
        return pick_operand();
    endfunction

    // Present one beat and hold it until the divider takes it.
    task automatic issue(op_t code, word_t num, word_t den);
        start    <= 1'b1;
        op       <= code;
        dividend <= num;
        divisor  <= den;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic maybe_idle(int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (owed != 0);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // divide by zero in every mode
        issue(OP_UQUO, ALL_ONES, '0);
        issue(OP_UREM, ALL_ONES, '0);
        issue(OP_SQUO, MOST_NEG, '0);
        issue(OP_SREM, word_t'(5), '0);
        // unsigned extremes
        issue(OP_UQUO, ALL_ONES, word_t'(1));
        issue(OP_UQUO, ALL_ONES, ALL_ONES);
        issue(OP_UREM, ALL_ONES, word_t'(2));
        issue(OP_UQUO, '0, ALL_ONES);
        issue(OP_UREM, word_t'(5), ALL_ONES);
        // most negative operand, including the wrap over minus one
        issue(OP_UQUO, MOST_NEG, word_t'(3));
        issue(OP_SQUO, MOST_NEG, ALL_ONES);
        issue(OP_SREM, MOST_NEG, ALL_ONES);
        issue(OP_SQUO, MOST_NEG, word_t'(1));
        issue(OP_SQUO, MOST_NEG, MOST_NEG);
        issue(OP_SREM, MOST_NEG, word_t'(3));
        issue(OP_SQUO, word_t'(3), MOST_NEG);
        // sign combinations
        issue(OP_SQUO, -word_t'(7), word_t'(2));
        issue(OP_SREM, -word_t'(7), word_t'(2));
        issue(OP_SQUO, word_t'(7), -word_t'(2));
        issue(OP_SREM, word_t'(7), -word_t'(2));
        issue(OP_SQUO, -word_t'(7), -word_t'(2));
        issue(OP_SREM, -word_t'(7), -word_t'(2));
        issue(OP_SQUO, MOST_POS, ALL_ONES);
        issue(OP_UREM, MOST_POS, MOST_NEG);

        for (int ph = 0; ph < 3; ph++)
        begin
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                issue(op_t'($urandom_range(0, 3)), pick_operand(), pick_divisor());
                // hold off once per phase until every answer is back
                if (i == ITEMS_PER_PHASE / 2)
                    drain();
                else
                    maybe_idle(idle_pct[ph]);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("divider_64bit_signed_unsigned verification clean");
        else
            $display("divider_64bit_signed_unsigned verification failed");
        $finish;
    end

endmodule
